// ===== rtl/core/sac_pkg.sv =====
// ----------------------------------------------------------------------------
// sac_pkg
// Shared widths, defaults, result type and a helper for the set-associative
// cache tag store.
// ----------------------------------------------------------------------------
package sac_pkg;

    localparam int BLK_W         = 9;
    localparam int CNT_W         = 16;
    localparam int NUM_LINES_DEF = 8;
    localparam int NUM_WAYS_DEF  = 2;

    typedef struct packed {
        logic             hit;
        logic             way_used;
        logic             evicted_valid;
        logic [BLK_W-1:0] evicted_block;
    } sac_res_t;

    // Bits needed to index n things, never less than one.
    function automatic int sac_width(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

endpackage

// ===== rtl/core/sac_tag_ram.sv =====
// ----------------------------------------------------------------------------
// sac_tag_ram
// Row memory holding one set per row: valid, age rank and block per way.
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module sac_tag_ram #(
    parameter int DEPTH  = 4,
    parameter int ADDR_W = 2,
    parameter int DATA_W = 22
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/sac_set_index.sv =====
// ----------------------------------------------------------------------------
// sac_set_index
// Captures the block number and works out its set, the block number modulo
// the number of sets, by a reciprocal multiply and a back-multiply.
// ----------------------------------------------------------------------------
module sac_set_index #(
    parameter int NUM_SETS = 4,
    parameter int SET_W    = 2
) (
    input  logic                      clk,
    input  logic                      load,
    input  logic [sac_pkg::BLK_W-1:0] block_number,
    output logic [sac_pkg::BLK_W-1:0] blk,
    output logic [SET_W-1:0]          set_idx
);
    import sac_pkg::*;

    // The reciprocal has enough fraction bits to make the quotient exact
    // for every block number.
    localparam int SHIFT   = BLK_W + SET_W;
    localparam int RECIP_W = SHIFT + 1;
    localparam longint RECIP = ((longint'(1) << SHIFT) + longint'(NUM_SETS) - 1)
                               / longint'(NUM_SETS);
    localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'(RECIP);
    localparam int PROD_W  = BLK_W + RECIP_W;
    localparam int MUL_W   = BLK_W + SET_W + 1;
    localparam int REM_W   = BLK_W + SET_W;

    logic [PROD_W-1:0] prod;
    logic [BLK_W-1:0]  quot_next;
    logic [BLK_W-1:0]  quot_reg;
    logic [BLK_W-1:0]  blk_reg;
    logic [MUL_W-1:0]  back_prod;
    logic [BLK_W-1:0]  rem;
    logic [REM_W-1:0]  rem_ext;

    assign prod      = PROD_W'(block_number) * PROD_W'(RECIP_C);
    assign quot_next = prod[SHIFT +: BLK_W];

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            blk_reg  <= block_number;
            quot_reg <= quot_next;
        end
    end

    assign back_prod = MUL_W'(quot_reg) * MUL_W'(NUM_SETS);
    assign rem       = blk_reg - back_prod[BLK_W-1:0];
    assign rem_ext   = REM_W'(rem);
    assign set_idx   = rem_ext[SET_W-1:0];
    assign blk       = blk_reg;

endmodule

// ===== rtl/core/sac_way_update.sv =====
// ----------------------------------------------------------------------------
// sac_way_update
// Compares one set row against a block number, picks the way to use (hit,
// first invalid, or lowest rank) and builds the updated row.
// ----------------------------------------------------------------------------
module sac_way_update #(
    parameter int NUM_WAYS = 2,
    parameter int RANK_W   = 1
) (
    input  logic [NUM_WAYS*(1+RANK_W+sac_pkg::BLK_W)-1:0] row,
    input  logic [sac_pkg::BLK_W-1:0]                     blk,
    input  logic                                          policy_lru,
    output logic [NUM_WAYS*(1+RANK_W+sac_pkg::BLK_W)-1:0] row_next,
    output sac_pkg::sac_res_t                             res
);
    import sac_pkg::*;

    localparam int ENTRY_W = 1 + RANK_W + BLK_W;
    localparam logic [RANK_W-1:0] TOP_RANK = RANK_W'(NUM_WAYS - 1);

    logic [NUM_WAYS-1:0] vld;
    logic [NUM_WAYS-1:0] match;
    logic [NUM_WAYS-1:0] hit_oh;
    logic [NUM_WAYS-1:0] inv_oh;
    logic [NUM_WAYS-1:0] vic_cand;
    logic [NUM_WAYS-1:0] vic_oh;
    logic [NUM_WAYS-1:0] way_oh;
    logic [RANK_W-1:0]   rnk [NUM_WAYS];
    logic [BLK_W-1:0]    tag [NUM_WAYS];
    logic [RANK_W-1:0]   old_rank;
    logic [RANK_W-1:0]   new_rank;
    logic                found_h;
    logic                found_i;
    logic                found_v;
    logic                touch;
    logic                way_odd;
    logic                evict;
    logic [BLK_W-1:0]    ev_blk;

    always_comb
    begin
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            tag[w]   = row[w*ENTRY_W +: BLK_W];
            rnk[w]   = row[w*ENTRY_W+BLK_W +: RANK_W];
            vld[w]   = row[w*ENTRY_W+BLK_W+RANK_W];
            match[w] = vld[w] && (tag[w] == blk);
        end

        // A way is the victim when its rank is below every lower way and not
        // above any higher way, so ties go to the lowest index.
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            vic_cand[w] = 1'b1;
            for (int v = 0; v < NUM_WAYS; v++)
            begin
                if ((v < w) && !(rnk[w] < rnk[v]))
                begin
                    vic_cand[w] = 1'b0;
                end
                if ((v > w) && !(rnk[w] <= rnk[v]))
                begin
                    vic_cand[w] = 1'b0;
                end
            end
        end

        found_h = 1'b0;
        found_i = 1'b0;
        found_v = 1'b0;
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            hit_oh[w] = match[w] & ~found_h;
            found_h   = found_h | match[w];
            inv_oh[w] = ~vld[w] & ~found_i;
            found_i   = found_i | ~vld[w];
            vic_oh[w] = vic_cand[w] & ~found_v;
            found_v   = found_v | vic_cand[w];
        end

        if (found_h)
        begin
            way_oh = hit_oh;
        end
        else if (found_i)
        begin
            way_oh = inv_oh;
        end
        else
        begin
            way_oh = vic_oh;
        end

        old_rank = '0;
        way_odd  = 1'b0;
        ev_blk   = '0;
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            if (way_oh[w])
            begin
                old_rank = old_rank | rnk[w];
                if ((w & 1) == 1)
                begin
                    way_odd = 1'b1;
                end
            end
            if (vic_oh[w])
            begin
                ev_blk = ev_blk | tag[w];
            end
        end

        evict = ~found_h & ~found_i;
        touch = ~found_h | policy_lru;

        for (int w = 0; w < NUM_WAYS; w++)
        begin
            new_rank = rnk[w];
            if (touch)
            begin
                if (way_oh[w])
                begin
                    new_rank = TOP_RANK;
                end
                else if (rnk[w] > old_rank)
                begin
                    new_rank = rnk[w] - 1'b1;
                end
            end
            row_next[w*ENTRY_W+BLK_W +: RANK_W] = new_rank;
            if (!found_h && way_oh[w])
            begin
                row_next[w*ENTRY_W +: BLK_W]       = blk;
                row_next[w*ENTRY_W+BLK_W+RANK_W]   = 1'b1;
            end
            else
            begin
                row_next[w*ENTRY_W +: BLK_W]       = tag[w];
                row_next[w*ENTRY_W+BLK_W+RANK_W]   = vld[w];
            end
        end

        res.hit           = found_h;
        res.way_used      = way_odd;
        res.evicted_valid = evict;
        res.evicted_block = evict ? ev_blk : '0;
    end

endmodule

// ===== rtl/core/set_assoc_cache_tag_fifo_lru.sv =====
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_fifo_lru
// Set-associative cache tag store with LRU or FIFO replacement.
//
// Usage: drive block_number and raise start; the item is taken at a clock
// edge where start is high and busy is low. The set row is read from the tag
// memory, compared, updated and written back. With the write-back, done is set
// and is then high for one cycle with hit, way_used, evicted_valid,
// evicted_block and hit_total; the receiver cannot stall, so each result is
// shown exactly once. The set index is registered before the row read and
// busy stays high until that read, so the next item is taken no earlier
// than the row write-back, which lands before the next item's row read.
// policy_lru is written through cfg_we and cfg_wdata; the user must do so only
// while no item is in flight (the block does not enforce it). It resets to LRU.
// After reset the tag memory is cleared one set per cycle, all NUM_LINES /
// NUM_WAYS sets (at least one); busy stays high until that is done.
// hit_total counts hits including the current item and saturates.
// ----------------------------------------------------------------------------
module set_assoc_cache_tag_fifo_lru #(
    parameter int NUM_LINES = sac_pkg::NUM_LINES_DEF,
    parameter int NUM_WAYS  = sac_pkg::NUM_WAYS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [sac_pkg::BLK_W-1:0] block_number,
    output logic                      busy,
    input  logic                      cfg_we,
    input  logic                      cfg_wdata,
    output logic                      done,
    output logic                      hit,
    output logic                      way_used,
    output logic                      evicted_valid,
    output logic [sac_pkg::BLK_W-1:0] evicted_block,
    output logic [sac_pkg::CNT_W-1:0] hit_total
);
    import sac_pkg::*;

    localparam int NUM_SETS = ((NUM_LINES / NUM_WAYS) > 0) ? (NUM_LINES / NUM_WAYS) : 1;
    localparam int SET_W    = sac_width(NUM_SETS);
    localparam int RANK_W   = sac_width(NUM_WAYS);
    localparam int ROW_W    = NUM_WAYS * (1 + RANK_W + BLK_W);
    localparam logic [SET_W-1:0] LAST_SET = SET_W'(NUM_SETS - 1);

    logic              accept;
    logic              clear_reg;
    logic              clear_next;
    logic [SET_W-1:0]  clear_addr_reg;
    logic [SET_W-1:0]  clear_addr_next;
    logic              s1_valid_reg;
    logic              s2_valid_reg;
    logic [BLK_W-1:0]  s2_blk_reg;
    logic [SET_W-1:0]  s2_set_reg;
    logic              done_reg;
    logic              policy_reg;
    logic              policy_next;
    logic [CNT_W-1:0]  hit_cnt_reg;
    logic [CNT_W-1:0]  hit_cnt_next;
    sac_res_t          res;
    sac_res_t          res_reg;

    logic [BLK_W-1:0]  s1_blk;
    logic [SET_W-1:0]  s1_set;
    logic              ram_we;
    logic [SET_W-1:0]  ram_waddr;
    logic [ROW_W-1:0]  ram_wdata;
    logic [ROW_W-1:0]  ram_rdata;
    logic [ROW_W-1:0]  row_next;

    assign busy   = clear_reg | s1_valid_reg;
    assign accept = start & ~busy;

    sac_set_index #(
        .NUM_SETS (NUM_SETS),
        .SET_W    (SET_W)
    ) u_set_index (
        .clk          (clk),
        .load         (accept),
        .block_number (block_number),
        .blk          (s1_blk),
        .set_idx      (s1_set)
    );

    sac_tag_ram #(
        .DEPTH  (NUM_SETS),
        .ADDR_W (SET_W),
        .DATA_W (ROW_W)
    ) u_tag_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (s1_valid_reg),
        .raddr (s1_set),
        .rdata (ram_rdata)
    );

    sac_way_update #(
        .NUM_WAYS (NUM_WAYS),
        .RANK_W   (RANK_W)
    ) u_way_update (
        .row        (ram_rdata),
        .blk        (s2_blk_reg),
        .policy_lru (policy_reg),
        .row_next   (row_next),
        .res        (res)
    );

    // The clearing pass and the write-back never overlap, since no item is
    // taken while clearing.
    assign ram_we    = clear_reg | s2_valid_reg;
    assign ram_waddr = clear_reg ? clear_addr_reg : s2_set_reg;
    assign ram_wdata = clear_reg ? '0 : row_next;

    always_comb
    begin
        clear_next      = clear_reg;
        clear_addr_next = clear_addr_reg;
        if (clear_reg)
        begin
            if (clear_addr_reg == LAST_SET)
            begin
                clear_next = 1'b0;
            end
            else
            begin
                clear_addr_next = clear_addr_reg + 1'b1;
            end
        end

        policy_next = cfg_we ? cfg_wdata : policy_reg;

        hit_cnt_next = hit_cnt_reg;
        if (s2_valid_reg && res.hit && (hit_cnt_reg != '1))
        begin
            hit_cnt_next = hit_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_reg      <= 1'b1;
            clear_addr_reg <= '0;
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            done_reg       <= 1'b0;
            policy_reg     <= 1'b1;
            hit_cnt_reg    <= '0;
        end
        else
        begin
            clear_reg      <= clear_next;
            clear_addr_reg <= clear_addr_next;
            s1_valid_reg   <= accept;
            s2_valid_reg   <= s1_valid_reg;
            done_reg       <= s2_valid_reg;
            policy_reg     <= policy_next;
            hit_cnt_reg    <= hit_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            s2_blk_reg <= s1_blk;
            s2_set_reg <= s1_set;
        end
        if (s2_valid_reg)
        begin
            res_reg <= res;
        end
    end

    assign done          = done_reg;
    assign hit           = res_reg.hit;
    assign way_used      = res_reg.way_used;
    assign evicted_valid = res_reg.evicted_valid;
    assign evicted_block = res_reg.evicted_block;
    assign hit_total     = hit_cnt_reg;

    // Only one item is in flight, so the read and write-back stages never
    // hold items at the same time.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        !(s1_valid_reg && s2_valid_reg))
        else $error("read and write-back stages both occupied");

    a_no_write_clash: assert property (@(posedge clk) disable iff (!rst_n)
        !(clear_reg && s2_valid_reg))
        else $error("write-back during clearing pass");

    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(s2_valid_reg))
        else $error("result strobe without a finished item");

    a_hit_xor_evict: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !(res_reg.hit && res_reg.evicted_valid))
        else $error("hit reported together with an eviction");

    a_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        hit_cnt_reg >= $past(hit_cnt_reg))
        else $error("hit count went down");

endmodule

// ===== verif/set_assoc_cache_tag_fifo_lru_test.sv =====
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_fifo_lru_test
// Self-checking bench for the set-associative cache tag store. A short table
// of accesses covers cold fills, hits, evictions and the block number
// extremes. Random phases under both replacement policies follow. Every
// result is checked against the table's typed result where one is given, or
// else against an in-bench model of the tags, valid bits and age ranks.
// ----------------------------------------------------------------------------
module set_assoc_cache_tag_fifo_lru_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LINES = sac_pkg::NUM_LINES_DEF;
    localparam int WAYS  = sac_pkg::NUM_WAYS_DEF;
    localparam int SETS  = (LINES / WAYS > 0) ? LINES / WAYS : 1;
    localparam int SLOTS = SETS * WAYS;

    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 4;
    localparam int PHASE_ITEMS  = 500;
    localparam int POOL_SIZE    = 10;
    localparam int N_ROWS       = 20;

    typedef struct packed {
        logic                      hit;
        logic                      way_used;
        logic                      evicted_valid;
        logic [sac_pkg::BLK_W-1:0] evicted_block;
        logic [sac_pkg::CNT_W-1:0] hit_total;
    } access_result_t;

    typedef struct packed {
        logic [sac_pkg::BLK_W-1:0] blk;
        logic                      typed;
        access_result_t            res;
    } access_row_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      start = 1'b0;
    logic [sac_pkg::BLK_W-1:0] block_number = '0;
    logic                      cfg_we = 1'b0;
    logic                      cfg_wdata = 1'b0;
    logic                      busy;
    logic                      done;
    logic                      hit;
    logic                      way_used;
    logic                      evicted_valid;
    logic [sac_pkg::BLK_W-1:0] evicted_block;
    logic [sac_pkg::CNT_W-1:0] hit_total;

    // Model state of the tag store.
    logic [sac_pkg::BLK_W-1:0] tag_block [SLOTS];
    logic                      tag_valid [SLOTS];
    int                        tag_rank  [SLOTS];
    logic [sac_pkg::CNT_W-1:0] hit_count;
    logic                      lru_mode;

    access_result_t expected_results [$];
    access_result_t oldest_result;
    int             mismatch_count = 0;
    int             idle_cycles = 0;

    // Rows with typed = 1 carry a result that follows directly from reset state.
    access_row_t directed_rows [N_ROWS] = '{
        '{9'd0,   1'b1, '{1'b0, 1'b0, 1'b0, 9'd0, 16'd0}},
        '{9'd4,   1'b1, '{1'b0, 1'b1, 1'b0, 9'd0, 16'd0}},
        '{9'd0,   1'b1, '{1'b1, 1'b0, 1'b0, 9'd0, 16'd1}},
        '{9'd8,   1'b0, '0},
        '{9'd4,   1'b0, '0},
        '{9'd511, 1'b1, '{1'b0, 1'b0, 1'b0, 9'd0, 16'd1}},
        '{9'd511, 1'b1, '{1'b1, 1'b0, 1'b0, 9'd0, 16'd2}},
        '{9'd255, 1'b0, '0},
        '{9'd1,   1'b0, '0},
        '{9'd5,   1'b0, '0},
        '{9'd9,   1'b0, '0},
        '{9'd1,   1'b0, '0},
        '{9'd2,   1'b0, '0},
        '{9'd6,   1'b0, '0},
        '{9'd2,   1'b0, '0},
        '{9'd10,  1'b0, '0},
        '{9'd256, 1'b0, '0},
        '{9'd341, 1'b0, '0},
        '{9'd170, 1'b0, '0},
        '{9'd507, 1'b0, '0}
    };

    set_assoc_cache_tag_fifo_lru DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .block_number  (block_number),
        .busy          (busy),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .done          (done),
        .hit           (hit),
        .way_used      (way_used),
        .evicted_valid (evicted_valid),
        .evicted_block (evicted_block),
        .hit_total     (hit_total)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            tag_block[i] = '0;
            tag_valid[i] = 1'b0;
            tag_rank[i]  = 0;
        end
        hit_count = '0;
        lru_mode  = 1'b1;
    end

    // The touched way takes the top rank; ranks above its old rank drop by one.
    function automatic void promote_way(input int base, input int way);
        int old_rank;
        old_rank = tag_rank[base + way];
        for (int w = 0; w < WAYS; w++)
        begin
            if (w != way && tag_rank[base + w] > old_rank)
                tag_rank[base + w]--;
        end
        tag_rank[base + way] = WAYS - 1;
    endfunction

    function automatic access_result_t lookup_and_update(input logic [sac_pkg::BLK_W-1:0] blk);
        access_result_t r;
        int             base;
        int             way;
        bit             matched;
        bit             free_found;
        r          = '0;
        base       = (int'(blk) % SETS) * WAYS;
        way        = 0;
        matched    = 1'b0;
        free_found = 1'b0;
        for (int w = 0; w < WAYS; w++)
        begin
            if (!matched && tag_valid[base + w] && tag_block[base + w] == blk)
            begin
                matched = 1'b1;
                way     = w;
            end
        end
        if (matched)
        begin
            r.hit = 1'b1;
            if (hit_count != '1)
                hit_count++;
            if (lru_mode)
                promote_way(base, way);
        end
        else
        begin
            for (int w = 0; w < WAYS; w++)
            begin
                if (!free_found && !tag_valid[base + w])
                begin
                    free_found = 1'b1;
                    way        = w;
                end
            end
            if (!free_found)
            begin
                way = 0;
                for (int w = 1; w < WAYS; w++)
                begin
                    if (tag_rank[base + w] < tag_rank[base + way])
                        way = w;
                end
                r.evicted_valid = 1'b1;
                r.evicted_block = tag_block[base + way];
            end
            tag_valid[base + way] = 1'b1;
            tag_block[base + way] = blk;
            promote_way(base, way);
        end
        r.way_used  = way[0];
        r.hit_total = hit_count;
        return r;
    endfunction

    // Called right after a rising edge; returns at the edge that took the item.
    task automatic issue_access(input logic [sac_pkg::BLK_W-1:0] blk, input bit typed,
                                input access_result_t typed_res);
        access_result_t predicted;
        start        <= 1'b1;
        block_number <= blk;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        predicted = lookup_and_update(blk);
        expected_results.push_back(typed ? typed_res : predicted);
    endtask

    task automatic idle_gap(input int cycles);
        start        <= 1'b0;
        block_number <= sac_pkg::BLK_W'($urandom);
        repeat (cycles) @(posedge clk);
    endtask

    // Lets every outstanding result arrive before the policy may change.
    task automatic settle();
        start <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_policy(input logic value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we   <= 1'b0;
        lru_mode = value;
    endtask

    function automatic int pick_gap();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic check_field(input string name, input logic [15:0] exp_v,
                               input logic [15:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t ns: %s expected %0d actual %0d", $time, name, exp_v, act_v);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t ns: result with no access outstanding", $time);
                mismatch_count++;
            end
            else
            begin
                oldest_result = expected_results.pop_front();
                check_field("hit", 16'(oldest_result.hit), 16'(hit));
                check_field("way_used", 16'(oldest_result.way_used), 16'(way_used));
                check_field("evicted_valid", 16'(oldest_result.evicted_valid),
                            16'(evicted_valid));
                check_field("evicted_block", 16'(oldest_result.evicted_block),
                            16'(evicted_block));
                check_field("hit_total", oldest_result.hit_total, hit_total);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        logic [sac_pkg::BLK_W-1:0] pool [POOL_SIZE];
        logic [sac_pkg::BLK_W-1:0] blk;
        int                        gap_pct;
        gap_pct  = 0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        set_policy(1'b1);

        foreach (directed_rows[i])
            issue_access(directed_rows[i].blk, directed_rows[i].typed, directed_rows[i].res);

        // Alternate FIFO and LRU phases of random traffic over a small hot set.
        for (int phase = 0; phase < 4; phase++)
        begin
            settle();
            set_policy(phase % 2 == 0 ? 1'b0 : 1'b1);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (i % 125 == 0)
                begin
                    foreach (pool[k])
                        pool[k] = sac_pkg::BLK_W'($urandom);
                end
                if (i % 50 == 0)
                begin
                    case ($urandom_range(0, 2))
                        0:       gap_pct = 0;
                        1:       gap_pct = 25;
                        default: gap_pct = 60;
                    endcase
                end
                if ($urandom_range(0, 99) < gap_pct)
                    idle_gap(pick_gap());
                if ($urandom_range(0, 99) < 75)
                    blk = pool[$urandom_range(0, POOL_SIZE - 1)];
                else
                    blk = sac_pkg::BLK_W'($urandom);
                issue_access(blk, 1'b0, '0);
            end
        end

        settle();
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
